// ----- rtl/lrp_pkg.sv -----
package lrp_pkg;

	localparam logic OP_LOAD    = 1'b0;
	localparam logic OP_FEATURE = 1'b1;

	// Fixed-point anchors of the exp and divide path
	localparam logic [63:0] Q60_ONE = 64'h1000_0000_0000_0000;
	localparam logic [63:0] Q54_ONE = 64'h0040_0000_0000_0000;
	localparam logic [63:0] Q38_ONE = 64'h0000_0040_0000_0000;
	localparam logic [63:0] E_ARG   = 64'h0000_0000_0001_0000;

	localparam logic signed [63:0] Z_LIMIT = 64'sh0000_0010_0000_0000;
	localparam logic [20:0] Z_MAX21 = 21'h0F_FFFF;
	localparam logic [20:0] Z_MIN21 = 21'h10_0000;

	localparam logic [4:0] SERIES_TERMS = 5'd26;
	localparam int SUM_QUEUE_DEPTH = 2;

	typedef struct packed {
		logic        start;
		logic [63:0] dividend;
		logic [63:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic        busy;
		logic        done;
		logic [63:0] quotient;
	} div_rsp_t;

	typedef enum logic [8:0] {
		S_INIT    = 9'b000000001,
		S_IDLE    = 9'b000000010,
		S_SER_MUL = 9'b000000100,
		S_SER_DIV = 9'b000001000,
		S_POW_MUL = 9'b000010000,
		S_Q_PREP  = 9'b000100000,
		S_Q_GO    = 9'b001000000,
		S_Q_DIV   = 9'b010000000,
		S_EMIT    = 9'b100000000
	} back_state_t;

endpackage

// ----- rtl/lrp_ram.sv -----
module lrp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 17
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/lrp_front.sv -----
module lrp_front import lrp_pkg::*; #(
	parameter int MAX_FEATURES = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               operation,
	input  logic [4:0]         weight_index,
	input  logic signed [31:0] value,
	input  logic [4:0]         feature_count,
	output logic               push,
	output logic [63:0]        push_sum,
	input  logic               q_full
);

	localparam int PW = $clog2(MAX_FEATURES + 1);

	logic          en, accept, feat, we;
	logic [PW-1:0] pos_q, np, lim;
	logic          first_w, last_w;
	logic [31:0]   rd_w;
	logic signed [31:0] wt_w;
	logic signed [63:0] prod_w;
	logic [63:0]   base_w, add_w, sat_w;

	logic signed [31:0] bias_q;
	logic               valid_s1, first_s1, last_s1;
	logic signed [31:0] value_s1, bias_s1;
	logic               valid_s2, first_s2, last_s2;
	logic signed [31:0] bias_s2;
	logic [63:0]        prod_s2;
	logic [63:0]        sum_q;

	// hold the whole feature path while a finished sum cannot enter the queue
	assign en       = !(valid_s2 && last_s2 && q_full);
	assign in_stall = !en;
	assign accept   = in_valid && en;
	assign feat     = accept && (operation == OP_FEATURE);
	assign we       = accept && (operation == OP_LOAD) && (int'(weight_index) <= MAX_FEATURES);

	always_comb begin
		if (feature_count == '0) begin
			lim = PW'(1);
		end else if (int'(feature_count) > MAX_FEATURES) begin
			lim = PW'(MAX_FEATURES);
		end else begin
			lim = PW'(feature_count);
		end
	end

	// pos_q never passes MAX_FEATURES-1, so np stays within the table
	assign np      = pos_q + PW'(1);
	assign first_w = (pos_q == '0);
	assign last_w  = (np >= lim);

	lrp_ram #(
		.WIDTH(32),
		.DEPTH(MAX_FEATURES + 1)
	) u_weights (
		.clk  (clk),
		.we   (we),
		.waddr(PW'(weight_index)),
		.wdata(value),
		.re   (feat),
		.raddr(np),
		.rdata(rd_w)
	);

	assign wt_w   = rd_w;
	assign prod_w = wt_w * value_s1;

	assign base_w = first_s2 ? {{16{bias_s2[31]}}, bias_s2, 16'h0000} : sum_q;
	assign add_w  = base_w + prod_s2;

	always_comb begin
		sat_w = add_w;
		if (base_w[63] == prod_s2[63] && add_w[63] != base_w[63]) begin
			sat_w = base_w[63] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
		end
	end

	assign push     = valid_s2 && last_s2 && !q_full;
	assign push_sum = sat_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			sum_q    <= '0;
		end else begin
			if (feat) begin
				pos_q <= last_w ? '0 : np;
			end
			if (en) begin
				valid_s1 <= feat;
				valid_s2 <= valid_s1;
				if (valid_s2) begin
					sum_q <= last_s2 ? '0 : sat_w;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (we && weight_index == '0) begin
			bias_q <= value;
		end
		if (en) begin
			value_s1 <= value;
			first_s1 <= first_w;
			last_s1  <= last_w;
			bias_s1  <= bias_q;
			prod_s2  <= prod_w;
			first_s2 <= first_s1;
			last_s2  <= last_s1;
			bias_s2  <= bias_s1;
		end
	end

endmodule

// ----- rtl/lrp_queue.sv -----
module lrp_queue #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             empty
);

	localparam int PTRW = $clog2(DEPTH);
	localparam int CNTW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTRW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CNTW-1:0]  count_q;

	assign full     = (count_q == CNTW'(DEPTH));
	assign empty    = (count_q == '0);
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTRW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTRW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ----- rtl/lrp_div.sv -----
module lrp_div import lrp_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic        busy_q, done_q;
	logic [5:0]  cnt_q;
	logic [63:0] rem_q, quo_q, dvs_q;
	logic [64:0] shifted, diff;
	logic        ge;

	// restoring divide, one quotient bit per cycle, dividend shifts out of quo_q
	assign shifted = {rem_q, quo_q[63]};
	assign diff    = shifted - {1'b0, dvs_q};
	assign ge      = !diff[64];

	assign rsp.busy     = busy_q;
	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[63:0] : shifted[63:0];
			quo_q <= {quo_q[62:0], ge};
		end
	end

endmodule

// ----- rtl/lrp_back.sv -----
module lrp_back import lrp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_empty,
	input  logic [63:0] q_data,
	output logic        q_pop,
	output div_req_t    div_req,
	input  div_rsp_t    div_rsp,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] probability
);

	back_state_t state_q;
	logic        init_q;
	logic [4:0]  k_q, n_q;
	logic [2:0]  mstep_q;
	logic        out_valid_q;

	logic [63:0]  ma_q, mb_q, sacc_q, e60_q, d_q, pp_q;
	logic [127:0] macc_q;
	logic [1:0]   pp_sh_q;
	logic         neg_q;
	logic [15:0]  res_q, prob_q;

	logic signed [63:0] sum_s, zsh;
	logic [20:0]  z21, mag_w;
	logic [31:0]  a_half, b_half;
	logic [63:0]  pp_w;
	logic [1:0]   sh_w;
	logic [127:0] pp_ext, macc_sum;
	logic         mul_last, emit_w;
	logic [63:0]  snew;
	logic [16:0]  qv;
	logic [15:0]  res_w;

	// z = sum floored and clipped to signed Q5.16, then split into sign and magnitude
	assign sum_s = q_data;
	assign zsh   = sum_s >>> 16;

	always_comb begin
		if (sum_s >= Z_LIMIT) begin
			z21 = Z_MAX21;
		end else if (sum_s < -Z_LIMIT) begin
			z21 = Z_MIN21;
		end else begin
			z21 = zsh[20:0];
		end
		mag_w = z21[20] ? (~z21 + 21'd1) : z21;
	end

	// 64x64 product as four 32x32 partials, one per cycle, each registered and summed in the cycle after
	assign a_half   = mstep_q[1] ? ma_q[63:32] : ma_q[31:0];
	assign b_half   = mstep_q[0] ? mb_q[63:32] : mb_q[31:0];
	assign pp_w     = a_half * b_half;
	assign sh_w     = {1'b0, mstep_q[1]} + {1'b0, mstep_q[0]};
	assign mul_last = (mstep_q == 3'd4);

	always_comb begin
		case (pp_sh_q)
			2'd0:    pp_ext = {64'h0, pp_q};
			2'd1:    pp_ext = {32'h0, pp_q, 32'h0};
			default: pp_ext = {pp_q, 64'h0};
		endcase
	end

	assign macc_sum = macc_q + pp_ext;
	assign snew     = sacc_q + div_rsp.quotient;

	assign qv = div_rsp.quotient[16:0];
	always_comb begin
		if (neg_q) begin
			res_w = qv[15:0];
		end else if (qv == '0) begin
			res_w = 16'hFFFF;
		end else begin
			res_w = 16'(17'h1_0000 - qv);
		end
	end

	always_comb begin
		div_req.start    = (state_q == S_SER_MUL && mul_last) || (state_q == S_Q_GO);
		div_req.dividend = macc_sum[79:16];
		div_req.divisor  = {59'h0, k_q};
		if (state_q == S_Q_GO) begin
			div_req.dividend = Q54_ONE + (d_q >> 1);
			div_req.divisor  = d_q;
		end
	end

	assign q_pop       = (state_q == S_IDLE) && !q_empty;
	assign emit_w      = (state_q == S_EMIT) && (!out_valid_q || !out_stall);
	assign out_valid   = out_valid_q;
	assign probability = prob_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			init_q      <= 1'b1;
			k_q         <= '0;
			n_q         <= '0;
			mstep_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_INIT: begin
					k_q     <= 5'd1;
					mstep_q <= '0;
					state_q <= S_SER_MUL;
				end
				S_IDLE: begin
					if (!q_empty) begin
						k_q     <= 5'd1;
						n_q     <= mag_w[20:16];
						mstep_q <= '0;
						state_q <= S_SER_MUL;
					end
				end
				S_SER_MUL: begin
					if (mul_last) begin
						state_q <= S_SER_DIV;
					end else begin
						mstep_q <= mstep_q + 3'd1;
					end
				end
				S_SER_DIV: begin
					if (div_rsp.done) begin
						mstep_q <= '0;
						if (k_q == SERIES_TERMS) begin
							init_q <= 1'b0;
							if (init_q) begin
								state_q <= S_IDLE;
							end else if (n_q == '0) begin
								state_q <= S_Q_PREP;
							end else begin
								state_q <= S_POW_MUL;
							end
						end else begin
							k_q     <= k_q + 5'd1;
							state_q <= S_SER_MUL;
						end
					end
				end
				S_POW_MUL: begin
					if (mul_last) begin
						n_q     <= n_q - 5'd1;
						mstep_q <= '0;
						if (n_q == 5'd1) begin
							state_q <= S_Q_PREP;
						end
					end else begin
						mstep_q <= mstep_q + 3'd1;
					end
				end
				S_Q_PREP: begin
					state_q <= S_Q_GO;
				end
				S_Q_GO: begin
					state_q <= S_Q_DIV;
				end
				S_Q_DIV: begin
					if (div_rsp.done) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (emit_w) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_INIT;
				end
			endcase

			if (emit_w) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_INIT: begin
				ma_q   <= Q60_ONE;
				mb_q   <= E_ARG;
				sacc_q <= Q60_ONE;
				macc_q <= '0;
			end
			S_IDLE: begin
				if (!q_empty) begin
					ma_q   <= Q60_ONE;
					mb_q   <= {48'h0, mag_w[15:0]};
					sacc_q <= Q60_ONE;
					macc_q <= '0;
					neg_q  <= z21[20];
				end
			end
			S_SER_MUL: begin
				if (!mul_last) begin
					pp_q    <= pp_w;
					pp_sh_q <= sh_w;
				end
				if (mstep_q != '0) begin
					macc_q <= macc_sum;
				end
			end
			S_SER_DIV: begin
				if (div_rsp.done) begin
					sacc_q <= snew;
					macc_q <= '0;
					if (k_q == SERIES_TERMS) begin
						if (init_q) begin
							e60_q <= snew;
						end else begin
							ma_q <= snew >> 22;
							mb_q <= e60_q;
						end
					end else begin
						ma_q <= div_rsp.quotient;
					end
				end
			end
			S_POW_MUL: begin
				if (mul_last) begin
					ma_q   <= macc_sum[123:60];
					macc_q <= '0;
				end else begin
					pp_q    <= pp_w;
					pp_sh_q <= sh_w;
					if (mstep_q != '0) begin
						macc_q <= macc_sum;
					end
				end
			end
			S_Q_PREP: begin
				d_q <= ma_q + Q38_ONE;
			end
			S_Q_DIV: begin
				if (div_rsp.done) begin
					res_q <= res_w;
				end
			end
			S_EMIT: begin
				if (emit_w) begin
					prob_q <= res_q;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// ----- rtl/logistic_regression_predict.sv -----
// Features and weight loads: one item per cycle while in_stall is low; a feature passes the weight
// read (s1) and product (s2) registers before it lands in the running sum, and a finished sum enters
// a two-entry queue to the scorer. Scoring: one sample at a time; the work per sample grows with n,
// the integer part of |z| (0..16), and is dominated by the 26-term exp series whose divide by the
// term index runs one quotient bit per cycle. Reset (arst_n, async, active low) clears control and
// sets feature_count to 1; weights hold no value until loaded. The scorer first derives e before its first sum.
module logistic_regression_predict import lrp_pkg::*; #(
	parameter int MAX_FEATURES = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               operation,
	input  logic [4:0]         weight_index,
	input  logic signed [31:0] value,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [4:0]         cfg_data,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [15:0]        probability
);

	logic [4:0]  feature_count_q;
	logic        q_push, q_full, q_pop, q_empty;
	logic [63:0] q_push_data, q_pop_data;
	div_req_t    div_req;
	div_rsp_t    div_rsp;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			feature_count_q <= 5'd1;
		end else if (cfg_valid && cfg_ready) begin
			feature_count_q <= cfg_data;
		end
	end

	lrp_front #(
		.MAX_FEATURES(MAX_FEATURES)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.operation    (operation),
		.weight_index (weight_index),
		.value        (value),
		.feature_count(feature_count_q),
		.push         (q_push),
		.push_sum     (q_push_data),
		.q_full       (q_full)
	);

	lrp_queue #(
		.WIDTH(64),
		.DEPTH(SUM_QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_data(q_push_data),
		.full     (q_full),
		.pop      (q_pop),
		.pop_data (q_pop_data),
		.empty    (q_empty)
	);

	lrp_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.rsp   (div_rsp)
	);

	lrp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (q_empty),
		.q_data     (q_pop_data),
		.q_pop      (q_pop),
		.div_req    (div_req),
		.div_rsp    (div_rsp),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.probability(probability)
	);

	a_div_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> !div_rsp.busy)
		else $error("divider restarted while busy");

	a_div_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> $past(div_rsp.busy))
		else $error("divider finished without running");

	a_stall_only_on_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> q_full)
		else $error("feature path stalled with room in the sum queue");

endmodule
